// ----- rtl/core/nssb_pkg.sv -----
// shared types and constants of the nearest-symbol-below search block
package nssb_pkg;

    localparam int unsigned DEPTH_DEFAULT = 1024;

    localparam int unsigned TYPE_W     = 8;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned INDEX_W    = 10;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SYMBOL_TYPE = 1'd1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [VALUE_W-1:0] NOT_FOUND_DIST = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic wr_entry;
        logic start;
        logic issue;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic last_issued;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/nssb_ctrl.sv -----
// controller state machine sequencing table writes and query scans
module nssb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_mode,
    output logic            o_ready,
    input  nssb_pkg::t_status i_status,
    output nssb_pkg::t_cmd    o_cmd
);
    import nssb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_mode == MODE_QUERY) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // all reads issued and the last compare retired
                if (i_status.last_issued && !i_status.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == S_IDLE);
        o_cmd.wr_entry = accept && i_mode == MODE_WRITE;
        o_cmd.start    = accept && i_mode == MODE_QUERY;
        o_cmd.issue    = (r_state == S_SCAN) && !i_status.last_issued;
        o_cmd.load     = (r_state == S_FINISH) && i_status.out_free;
    end

endmodule

// ----- rtl/core/nssb_datapath.sv -----
// symbol table memory, scan counter, best-match tracking and result register
module nssb_datapath #(
    parameter int unsigned TABLE_DEPTH = nssb_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nssb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nssb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [nssb_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [nssb_pkg::TYPE_W-1:0]       i_entry_type,
    input  logic [nssb_pkg::VALUE_W-1:0]      i_entry_value,
    input  logic [nssb_pkg::VALUE_W-1:0]      i_query_addr,
    input  logic [nssb_pkg::TYPE_W-1:0]       i_query_type,
    input  nssb_pkg::t_cmd                    i_cmd,
    output nssb_pkg::t_status                 o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_found,
    output logic [nssb_pkg::INDEX_W-1:0]      o_match_index,
    output logic [nssb_pkg::VALUE_W-1:0]      o_distance
);
    import nssb_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned EW = TYPE_W + VALUE_W;

    logic [EW-1:0]      r_mem [TABLE_DEPTH];
    logic [EW-1:0]      r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_len;
    logic [VALUE_W-1:0] r_qaddr;
    logic [TYPE_W-1:0]  r_qtype;
    logic [LEN_W-1:0]   r_table_length;
    logic [TYPE_W-1:0]  r_no_symbol_type;
    logic               r_hit;
    logic [AW-1:0]      r_best_idx;
    logic [VALUE_W-1:0] r_best_dist;
    logic               r_out_valid;
    logic               r_found;
    logic [INDEX_W-1:0] r_idx;
    logic [VALUE_W-1:0] r_dist;

    logic [31:0]        wr_idx_wide;
    logic               wr_in_range;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        len_wide;
    logic [CW-1:0]      len_clamped;
    logic [TYPE_W-1:0]  rd_type;
    logic [VALUE_W-1:0] rd_value;
    logic [VALUE_W-1:0] cand_dist;
    logic               better;
    logic [31:0]        best_idx_wide;

    assign wr_idx_wide = 32'(i_entry_index);
    assign wr_in_range = wr_idx_wide < 32'(TABLE_DEPTH);
    assign wr_addr     = wr_idx_wide[AW-1:0];

    assign len_wide    = (32'(r_table_length) > 32'(TABLE_DEPTH)) ?
                         32'(TABLE_DEPTH) : 32'(r_table_length);
    assign len_clamped = len_wide[CW-1:0];

    assign rd_type   = r_rd_data[EW-1:VALUE_W];
    assign rd_value  = r_rd_data[VALUE_W-1:0];
    assign cand_dist = r_qaddr - rd_value;
    assign better    = r_rd_vld && (rd_type == r_qtype) && (rd_value <= r_qaddr) &&
                       (!r_hit || cand_dist < r_best_dist);

    assign best_idx_wide = 32'(r_best_idx);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length   <= '0;
            r_no_symbol_type <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TABLE_LENGTH:   r_table_length   <= i_cfg_data[LEN_W-1:0];
                CFG_NO_SYMBOL_TYPE: r_no_symbol_type <= i_cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // symbol table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && wr_in_range) begin
            r_mem[wr_addr] <= {i_entry_type, i_entry_value};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_cnt[AW-1:0]];
            r_rd_idx  <= r_cnt[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
            r_len    <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_cnt <= '0;
                // no-symbol type queries scan nothing
                r_len <= (i_query_type == r_no_symbol_type) ? '0 : len_clamped;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (better) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qaddr <= i_query_addr;
            r_qtype <= i_query_type;
        end
        if (better) begin
            r_best_idx  <= r_rd_idx;
            r_best_dist <= cand_dist;
        end
    end

    // result register, freed when the receiver takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= r_hit;
            r_idx   <= r_hit ? best_idx_wide[INDEX_W-1:0] : '0;
            r_dist  <= r_hit ? r_best_dist : NOT_FOUND_DIST;
        end
    end

    assign o_status.last_issued = (r_cnt >= r_len);
    assign o_status.pipe_busy   = r_rd_vld;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_idx;
    assign o_distance    = r_dist;

endmodule

// ----- rtl/core/nearest_symbol_below_search.sv -----
// top level of the nearest-symbol-below search block
//
// Input channel (i_valid / o_ready) carries one item per handshake. A write
// item (mode 0) stores entry_type and entry_value at entry_index and gives no
// result; writes are taken one per cycle while no query runs. A query item
// (mode 1) scans table entries 0 .. min(table_length, TABLE_DEPTH)-1 through the
// single read port of the symbol table, one entry per cycle, and keeps the nearest
// entry of the same type at or below query_addr (the first one on a tie).
// A no-symbol type query scans no entries. The block takes no new item while a
// query runs, from acceptance until its result is loaded into the result register.
// Output channel (o_valid / i_ready) has a result register: a following item
// is accepted while a result waits. If the receiver stalls, a finished query
// holds in its last state until the register frees.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 table_length, 1 no_symbol_type); the user must write only while the block
// is idle; the block does not enforce this. Reset (i_rst_n low, synchronous) clears
// the registers and control state; table contents are undefined until written.
module nearest_symbol_below_search #(
    parameter int unsigned TABLE_DEPTH = nssb_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nssb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nssb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [nssb_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [nssb_pkg::TYPE_W-1:0]       i_entry_type,
    input  logic [nssb_pkg::VALUE_W-1:0]      i_entry_value,
    input  logic [nssb_pkg::VALUE_W-1:0]      i_query_addr,
    input  logic [nssb_pkg::TYPE_W-1:0]       i_query_type,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_found,
    output logic [nssb_pkg::INDEX_W-1:0]      o_match_index,
    output logic [nssb_pkg::VALUE_W-1:0]      o_distance
);
    import nssb_pkg::*;

    t_cmd    cmd;
    t_status status;

    nssb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nssb_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_type  (i_entry_type),
        .i_entry_value (i_entry_value),
        .i_query_addr  (i_query_addr),
        .i_query_type  (i_query_type),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .o_distance    (o_distance)
    );

`ifndef SYNTHESIS
    // no item is taken while a table read is still in flight
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.pipe_busy |-> !o_ready)
        else $error("input accepted during scan");

    // a result only appears after the controller loaded one
    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(cmd.load))
        else $error("result without load");

    // a not-found result carries index 0 and the maximum distance
    a_not_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_index == '0 && o_distance == NOT_FOUND_DIST))
        else $error("bad not-found result");

    // writes and query starts never coincide, nor table reads and result loads
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_entry && cmd.start) && !(cmd.issue && cmd.load))
        else $error("conflicting commands");
`endif

endmodule

// ----- sim/tb_nearest_symbol_below_search.sv -----
// testbench for the nearest-symbol-below search block: directed and random traffic, self-checking
`timescale 1ns / 1ps

module tb_nearest_symbol_below_search;
    import nssb_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int BURST_ITEMS   = 97;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic               mode;
        logic [INDEX_W-1:0] entry_index;
        logic [TYPE_W-1:0]  entry_type;
        logic [VALUE_W-1:0] entry_value;
        logic [VALUE_W-1:0] query_addr;
        logic [TYPE_W-1:0]  query_type;
    } t_sym_item;

    typedef struct {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic [VALUE_W-1:0] distance;
    } t_lookup_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_mode;
    logic [INDEX_W-1:0]    i_entry_index;
    logic [TYPE_W-1:0]     i_entry_type;
    logic [VALUE_W-1:0]    i_entry_value;
    logic [VALUE_W-1:0]    i_query_addr;
    logic [TYPE_W-1:0]     i_query_type;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_found;
    logic [INDEX_W-1:0]    o_match_index;
    logic [VALUE_W-1:0]    o_distance;

    // mirror of the symbol table and the registers
    logic [TYPE_W-1:0]  shadow_types [DEPTH];
    logic [VALUE_W-1:0] shadow_values [DEPTH];
    bit                 written [DEPTH];
    int                 written_prefix = 0;
    logic [LEN_W-1:0]   cfg_len = '0;
    logic [TYPE_W-1:0]  cfg_no_sym = '0;
    logic [TYPE_W-1:0]  type_pool [4];

    t_lookup_result lookup_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_writes      = 0;
    int n_queries     = 0;
    int n_results     = 0;
    int n_found       = 0;
    int n_errors      = 0;
    int cycle_count   = 0;

    nearest_symbol_below_search #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lookups pending", cycle_count,
                     lookup_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_lookup_result predict_lookup(input logic [VALUE_W-1:0] addr,
                                                      input logic [TYPE_W-1:0]  qtype);
        t_lookup_result r;
        int span;
        int best_dist;
        span = (cfg_len > DEPTH) ? DEPTH : int'(cfg_len);
        r.found = 1'b0;
        r.match_index = '0;
        r.distance = NOT_FOUND_DIST;
        best_dist = 0;
        if (qtype != cfg_no_sym) begin
            for (int i = 0; i < span; i++) begin
                if (shadow_types[i] == qtype && shadow_values[i] <= addr &&
                    (!r.found || int'(addr) - int'(shadow_values[i]) < best_dist)) begin
                    r.found = 1'b1;
                    r.match_index = INDEX_W'(i);
                    best_dist = int'(addr) - int'(shadow_values[i]);
                    if (best_dist == 0) break;
                end
            end
        end
        if (r.found) r.distance = VALUE_W'(best_dist);
        return r;
    endfunction

    // values drawn near existing entries so that ties and exact hits are common
    function automatic logic [VALUE_W-1:0] pick_value(input int span);
        int known;
        int roll;
        logic [VALUE_W-1:0] base;
        known = (written_prefix < span) ? written_prefix : span;
        roll = $urandom_range(0, 99);
        base = (known > 0) ? shadow_values[$urandom_range(0, known - 1)] : VALUE_W'($urandom());
        if (roll < 30) return base;
        if (roll < 50) return base + VALUE_W'($urandom_range(1, 40));
        if (roll < 60) return roll[0] ? '1 : '0;
        return VALUE_W'($urandom());
    endfunction

    function automatic logic [TYPE_W-1:0] pick_entry_type();
        if ($urandom_range(0, 99) < 85) return type_pool[$urandom_range(0, 3)];
        return TYPE_W'($urandom());
    endfunction

    function automatic logic [TYPE_W-1:0] pick_query_type();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return type_pool[$urandom_range(0, 3)];
        if (roll < 85) return cfg_no_sym;
        return TYPE_W'($urandom());
    endfunction

    // one item through the input handshake, then the mirror follows it
    task automatic send_item(input t_sym_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= it.mode;
        i_entry_index <= it.entry_index;
        i_entry_type  <= it.entry_type;
        i_entry_value <= it.entry_value;
        i_query_addr  <= it.query_addr;
        i_query_type  <= it.query_type;
        do @(posedge i_clk); while (!o_ready);
        if (it.mode == MODE_WRITE) begin
            shadow_types[it.entry_index]  = it.entry_type;
            shadow_values[it.entry_index] = it.entry_value;
            written[it.entry_index] = 1'b1;
            while (written_prefix < DEPTH && written[written_prefix]) written_prefix++;
            n_writes++;
        end else begin
            lookup_q.push_back(predict_lookup(it.query_addr, it.query_type));
            n_queries++;
        end
    endtask

    // unused fields of each item carry random junk
    task automatic send_write(input int idx, input logic [TYPE_W-1:0] typ,
                              input logic [VALUE_W-1:0] val);
        t_sym_item it;
        it.mode        = MODE_WRITE;
        it.entry_index = INDEX_W'(idx);
        it.entry_type  = typ;
        it.entry_value = val;
        it.query_addr  = VALUE_W'($urandom());
        it.query_type  = TYPE_W'($urandom());
        send_item(it);
    endtask

    task automatic send_query(input logic [VALUE_W-1:0] addr, input logic [TYPE_W-1:0] typ);
        t_sym_item it;
        it.mode        = MODE_QUERY;
        it.entry_index = INDEX_W'($urandom());
        it.entry_type  = TYPE_W'($urandom());
        it.entry_value = VALUE_W'($urandom());
        it.query_addr  = addr;
        it.query_type  = typ;
        send_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] nst_data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TABLE_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(len);
        @(posedge i_clk);
        i_cfg_index <= CFG_NO_SYMBOL_TYPE;
        i_cfg_data  <= nst_data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_len    = len;
        cfg_no_sym = nst_data[TYPE_W-1:0];
    endtask

    // mostly lookups over a fully written prefix; entries below the length get filled first
    task automatic random_burst(input int n_items, input logic [LEN_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] nst_data);
        int span;
        int hi;
        int idx;
        set_config(len, nst_data);
        span = int'(len);
        hi = (span + 3 > DEPTH - 1) ? DEPTH - 1 : span + 3;
        foreach (type_pool[j]) type_pool[j] = TYPE_W'($urandom());
        for (int n = 0; n < n_items; n++) begin
            if (written_prefix < span) begin
                send_write(written_prefix, pick_entry_type(), pick_value(span));
            end else if ($urandom_range(0, 99) < 40) begin
                idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH - 1)
                                                  : $urandom_range(0, hi);
                send_write(idx, pick_entry_type(), pick_value(span));
            end else begin
                send_query(pick_value(span), pick_query_type());
            end
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        set_config(6, 11'h010);
        send_write(0, 8'h05, 16'd100);
        send_write(1, 8'h05, 16'd100);
        send_write(2, 8'h07, 16'd0);
        send_write(3, 8'h05, 16'd200);
        send_write(4, 8'h10, 16'd50);
        send_write(5, 8'hFF, 16'hFFFF);
        send_write(DEPTH - 1, 8'h5A, 16'h8000);
        send_query(16'd150, 8'h05);     // tie on value, first entry wins
        send_query(16'd100, 8'h05);     // exact hit
        send_query(16'd99, 8'h05);      // every candidate above the address
        send_query(16'hFFFF, 8'h05);
        send_query(16'hFFFF, 8'h07);    // hit with the largest distance
        send_query(16'd0, 8'h07);
        send_query(16'd60, 8'h10);      // no-symbol code
        send_query(16'hFFFF, 8'hFF);
        send_query(16'd1000, 8'h33);    // type absent from the table
        set_config(0, 11'h000);
        send_query(16'd150, 8'h05);
        send_query(16'd150, 8'h00);
        set_config(2, 11'h0FF);
        send_query(16'd300, 8'h05);
    endtask

    task automatic test_busy_receiver();
        send_idle_pct = 13;
        recv_idle_pct = 67;
        random_burst(BURST_ITEMS, 24, 11'h7C5);
        random_burst(BURST_ITEMS, 1, 11'h0FF);
    endtask

    task automatic test_busy_sender();
        send_idle_pct = 67;
        recv_idle_pct = 13;
        random_burst(BURST_ITEMS, 64, 11'h000);
        random_burst(BURST_ITEMS, 9, 11'h003);
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(BURST_ITEMS, 40, 11'h080);
        random_burst(BURST_ITEMS, 17, 11'h400);
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        i_ready <= !i_rst_n ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (lookup_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected result: found %0b index %0d distance %0d",
                             o_found, o_match_index, o_distance);
            end else begin
                want = lookup_q.pop_front();
                if (want.found) n_found++;
                if (o_found !== want.found || o_match_index !== want.match_index ||
                    o_distance !== want.distance) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("result %0d: expected found %0b index %0d distance %0d, %s",
                                 n_results, want.found, want.match_index, want.distance,
                                 $sformatf("got found %0b index %0d distance %0d",
                                           o_found, o_match_index, o_distance));
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_mode        = MODE_WRITE;
        i_entry_index = '0;
        i_entry_type  = '0;
        i_entry_value = '0;
        i_query_addr  = '0;
        i_query_type  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_busy_receiver();
        test_busy_sender();
        test_back_to_back();
        drain();

        $display("%0d table writes and %0d lookups sent, %0d results checked (%0d hits), %0d errors",
                 n_writes, n_queries, n_results, n_found, n_errors);
        $display("table lengths 0 to 64, several no-symbol codes, stalls on either side");
        if (n_errors == 0 && lookup_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
